### hdl/wfd_pkg.sv
// Shared definitions for the WebSocket frame deframer: widths, reset values,
// action and error codes, and the UTF-8 checker status struct.
// No dependencies.
`timescale 1ns / 1ps

package wfd_pkg;

   // Width of the payload length and byte-left counters
   localparam int LEN_BITS = 24;
   // Configuration register width and reset value
   localparam int MAX_BITS = 24;
   localparam logic [MAX_BITS-1:0] MAX_FRAME_RESET = 24'd16384;
   // Width used when comparing a payload length against the remaining room
   localparam int CMP_BITS = (LEN_BITS > MAX_BITS) ? LEN_BITS : MAX_BITS;

   // Header byte count width (longest header is 14 bytes)
   localparam int HDR_BITS = 4;

   // Frame end actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_DELIVER = 3'd1;
   localparam logic [2:0] ACT_DISCARD = 3'd2;
   localparam logic [2:0] ACT_CLOSE   = 3'd3;
   localparam logic [2:0] ACT_PONG    = 3'd4;
   localparam logic [2:0] ACT_IGNORE  = 3'd5;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_PROTOCOL = 3'd1;
   localparam logic [2:0] ERR_UNMASKED = 3'd2;
   localparam logic [2:0] ERR_TOO_BIG  = 3'd3;
   localparam logic [2:0] ERR_UTF8     = 3'd4;

   // Opcodes with a meaning of their own
   localparam logic [3:0] OP_TEXT       = 4'h1;
   localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING       = 4'h9;
   localparam logic [3:0] OP_PONG       = 4'hA;

   // Length byte codes for extended lengths
   localparam logic [6:0] LEN7_EXT16 = 7'h7E;
   localparam logic [6:0] LEN7_EXT64 = 7'h7F;

   // UTF-8 checker status after the byte now being fed
   typedef struct packed {
      logic bad;        // an invalid sequence has been seen
      logic open;       // a code point is still waiting for continuation bytes
   } utf8_status_type;

endpackage

### hdl/wfd_channels.sv
// Channel interfaces of the deframer: input bytes, result items and the
// configuration write port. Depends on wfd_pkg.
`timescale 1ns / 1ps

interface wfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface wfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic [3:0] frame_opcode;
   logic       frame_end;
   logic [2:0] action;
   logic [2:0] error_code;

   modport source (output valid, output out_byte, output has_byte, output frame_opcode,
                   output frame_end, output action, output error_code, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input frame_opcode,
                   input frame_end, input action, input error_code, output ready);
endinterface

interface wfd_csr_if;
   import wfd_pkg::*;
   logic                valid;
   logic                ready;
   logic [MAX_BITS-1:0] max_frame_bytes;

   modport source (output valid, output max_frame_bytes, input ready);
   modport sink   (input valid, input max_frame_bytes, output ready);
endinterface

### hdl/wfd_utf8.sv
// Streaming UTF-8 validity checker for final text frames.
// Holds the pending continuation count and partial code point. Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_utf8 (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,     // start of a new frame
   input  logic                     feed,      // consume data_byte this cycle
   input  logic [7:0]               data_byte,
   output wfd_pkg::utf8_status_type status    // state after data_byte is taken
);
   import wfd_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] point_ff, point_in;
   logic        bad_ff, bad_in;

   // Next checker state assuming data_byte is fed
   always_comb begin
      pending_in = pending_ff;
      point_in   = point_ff;
      bad_in     = bad_ff;
      if (!bad_ff) begin
         if (pending_ff == 2'd0) begin
            // Lead byte: count the leading ones; ASCII needs no tracking
            if (data_byte[7]) begin
               if (data_byte[7:5] == 3'b110) begin
                  pending_in = 2'd1;
                  point_in   = {16'd0, data_byte[4:0]};
               end else if (data_byte[7:4] == 4'b1110) begin
                  pending_in = 2'd2;
                  point_in   = {17'd0, data_byte[3:0]};
               end else if (data_byte[7:3] == 5'b11110) begin
                  pending_in = 2'd3;
                  point_in   = {18'd0, data_byte[2:0]};
               end else begin
                  bad_in = 1'b1;   // stray continuation or too many ones
               end
            end
         end else if (data_byte[7:6] != 2'b10) begin
            bad_in = 1'b1;
         end else begin
            point_in   = {point_ff[14:0], data_byte[5:0]};
            pending_in = pending_ff - 2'd1;
            // Completed code point: beyond Unicode range or a surrogate
            if (pending_ff == 2'd1 &&
                (point_in > 21'h10FFFF || point_in[20:11] == 10'd27)) begin
               bad_in = 1'b1;
            end
         end
      end
   end

   assign status.bad  = bad_in;
   assign status.open = (pending_in != 2'd0);

   // Checker state
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pending_ff <= 2'd0;
         point_ff   <= 21'd0;
         bad_ff     <= 1'b0;
      end else if (feed) begin
         pending_ff <= pending_in;
         point_ff   <= point_in;
         bad_ff     <= bad_in;
      end
   end

endmodule

### hdl/websocket_frame_deframer_core.sv
// WebSocket client-to-server frame deframer, top level.
// Depends on wfd_pkg, the channel interfaces and wfd_utf8.
//
// Usage:
//   req_if carries the received stream, one byte per transaction.
//   rsp_if gives at most one result per input byte: an unmasked payload byte,
//   a frame end with its action, or an error. Header bytes give no result
//   unless they raise an error or end a frame with an empty payload.
//   csr_if writes max_frame_bytes (header plus payload limit); it is always
//   ready and is meant to be written only while the block is idle.
// Path: an accepted byte goes from the input register through the
//   header/unmask logic into the result register that drives rsp_if.
// Throughput: one byte per cycle when not stalled (see Stall); the parse state
//   is updated once per byte by a single pass of logic from the input register.
// Reset (synchronous): the parser waits for a first header byte and
//   max_frame_bytes returns to 16384.
// Stall: when rsp_if is not ready the result register holds its item, the
//   input register holds the next byte, and req_if drops ready. Bytes that
//   produce no result keep moving through.
// After the first error the block reports it once and ignores all further
//   bytes until reset.
`timescale 1ns / 1ps

module websocket_frame_deframer_core (
   input  logic      clock,
   input  logic      reset,
   wfd_req_if.sink   req_if,
   wfd_rsp_if.source rsp_if,
   wfd_csr_if.sink   csr_if
);
   import wfd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR, PH_LEN, PH_EXT16, PH_EXT64, PH_MASK, PH_PAYLOAD, PH_DEAD
   } phase_type;

   // Configuration
   logic [MAX_BITS-1:0] max_ff;

   // Input register
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;

   // Parse state
   phase_type           phase_ff, phase_in;
   logic                fin_ff, fin_in;
   logic [3:0]          op_ff, op_in;
   logic [2:0]          idx_ff, idx_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic                big_ff, big_in;   // length does not fit LEN_BITS
   logic [31:0]         mask_ff, mask_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic [HDR_BITS-1:0] hdr_ff, hdr_in;

   // Result register
   logic       rsp_vld_ff;
   logic [7:0] out_byte_ff;
   logic       has_byte_ff;
   logic [3:0] opcode_ff;
   logic       end_ff;
   logic [2:0] action_ff;
   logic [2:0] error_ff;

   // Result of this cycle's byte
   logic       produce;
   logic [7:0] r_byte;
   logic       r_has;
   logic       r_end;
   logic [2:0] r_action;
   logic [2:0] r_error;

   logic            advance;
   logic            utf_clear;
   logic            utf_feed;
   utf8_status_type utf_status;

   logic [HDR_BITS-1:0] hdr_count;
   logic [7:0]          plain;
   logic [CMP_BITS-1:0] room;
   logic [CMP_BITS-1:0] len_wide;
   logic [2:0]          ext_last;

   // Checker only moves when the payload byte really advances
   wfd_utf8 u_utf8 (
      .clock     (clock),
      .reset     (reset),
      .clear     (utf_clear),
      .feed      (utf_feed && advance),
      .data_byte (plain),
      .status    (utf_status)
   );

   assign plain     = in_byte_ff ^ mask_ff[7:0];
   assign hdr_count = ((phase_ff == PH_HDR) ? '0 : hdr_ff) + HDR_BITS'(1);
   assign room      = CMP_BITS'(max_ff) - CMP_BITS'(hdr_count);
   assign len_wide  = CMP_BITS'(len_ff);
   assign ext_last  = (phase_ff == PH_EXT16) ? 3'd1 : 3'd7;

   // Per-byte parse: next state and result
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      big_in    = big_ff;
      mask_in   = mask_ff;
      left_in   = left_ff;
      hdr_in    = hdr_ff;
      produce   = 1'b0;
      r_byte    = 8'd0;
      r_has     = 1'b0;
      r_end     = 1'b0;
      r_action  = ACT_NONE;
      r_error   = ERR_NONE;
      utf_clear = 1'b0;
      utf_feed  = 1'b0;

      if (phase_ff == PH_PAYLOAD) begin
         // Unmask and emit a payload byte
         mask_in  = {mask_ff[7:0], mask_ff[31:8]};
         utf_feed = fin_ff && (op_ff == OP_TEXT);
         left_in  = left_ff - LEN_BITS'(1);
         produce  = 1'b1;
         r_byte   = plain;
         r_has    = 1'b1;
         r_end    = (left_ff == LEN_BITS'(1));
      end else if (phase_ff != PH_DEAD) begin
         utf_clear = (phase_ff == PH_HDR);
         hdr_in    = hdr_count;
         if (MAX_BITS'(hdr_count) > max_ff) begin
            produce = 1'b1;
            r_error = ERR_TOO_BIG;
         end else begin
            case (phase_ff)
               PH_HDR: begin
                  fin_in = in_byte_ff[7];
                  op_in  = in_byte_ff[3:0];
                  if (in_byte_ff[6:4] != 3'd0 || (in_byte_ff[3] && !in_byte_ff[7])) begin
                     produce = 1'b1;
                     r_error = ERR_PROTOCOL;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  idx_in  = 3'd0;
                  mask_in = 32'd0;
                  if (!in_byte_ff[7]) begin
                     produce = 1'b1;
                     r_error = ERR_UNMASKED;
                  end else if (in_byte_ff[6:0] == LEN7_EXT16 ||
                               in_byte_ff[6:0] == LEN7_EXT64) begin
                     if (op_ff[3]) begin
                        produce = 1'b1;
                        r_error = ERR_PROTOCOL;
                     end else begin
                        len_in   = '0;
                        big_in   = 1'b0;
                        phase_in = (in_byte_ff[6:0] == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
                     end
                  end else begin
                     len_in   = LEN_BITS'(in_byte_ff[6:0]);
                     big_in   = 1'b0;
                     phase_in = PH_MASK;
                  end
               end
               PH_EXT16, PH_EXT64: begin
                  // Big-endian length; remember bits shifted off the top
                  len_in = LEN_BITS'({len_ff, in_byte_ff});
                  big_in = big_ff || (len_ff[LEN_BITS-1 -: 8] != 8'd0);
                  idx_in = idx_ff + 3'd1;
                  if (idx_ff == ext_last) begin
                     idx_in   = 3'd0;
                     mask_in  = 32'd0;
                     phase_in = PH_MASK;
                  end
               end
               PH_MASK: begin
                  mask_in = mask_ff | ({24'd0, in_byte_ff} << {idx_ff[1:0], 3'b000});
                  idx_in  = idx_ff + 3'd1;
                  if (idx_ff == 3'd3) begin
                     idx_in = 3'd0;
                     if (big_ff || len_wide > room) begin
                        produce = 1'b1;
                        r_error = ERR_TOO_BIG;
                     end else begin
                        left_in  = len_ff;
                        phase_in = PH_PAYLOAD;
                        if (len_ff == '0) begin
                           produce = 1'b1;
                           r_end   = 1'b1;
                        end
                     end
                  end
               end
               default: phase_in = PH_DEAD;
            endcase
         end
         if (r_error != ERR_NONE) begin
            phase_in = PH_DEAD;
         end
      end

      // Frame end: pick the action or a late error
      if (r_end) begin
         if (op_ff[3]) begin
            case (op_ff)
               OP_CONN_CLOSE: r_action = ACT_CLOSE;
               OP_PING:       r_action = ACT_PONG;
               OP_PONG:       r_action = ACT_IGNORE;
               default:       r_error  = ERR_PROTOCOL;
            endcase
         end else if (fin_ff) begin
            // An empty text frame feeds nothing and is always well formed
            if (utf_feed && (utf_status.bad || utf_status.open)) begin
               r_error = ERR_UTF8;
            end else begin
               r_action = ACT_DELIVER;
            end
         end else begin
            r_action = ACT_DISCARD;
         end
         phase_in = (r_error != ERR_NONE) ? PH_DEAD : PH_HDR;
      end
   end

   // Flow control: a byte with no result moves on even when the output is full
   assign advance       = in_vld_ff && (!produce || !rsp_vld_ff || rsp_if.ready);
   assign req_if.ready  = !in_vld_ff || advance;
   assign csr_if.ready  = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_FRAME_RESET;
      end else if (csr_if.valid) begin
         max_ff <= csr_if.max_frame_bytes;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.in_byte;
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         fin_ff   <= 1'b0;
         op_ff    <= 4'd0;
         idx_ff   <= 3'd0;
         len_ff   <= '0;
         big_ff   <= 1'b0;
         mask_ff  <= 32'd0;
         left_ff  <= '0;
         hdr_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         big_ff   <= big_in;
         mask_ff  <= mask_in;
         left_ff  <= left_in;
         hdr_ff   <= hdr_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && produce) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_byte_ff <= r_byte;
         has_byte_ff <= r_has;
         opcode_ff   <= op_in;
         end_ff      <= r_end && (r_error == ERR_NONE || r_error == ERR_PROTOCOL ||
                                  r_error == ERR_UTF8);
         action_ff   <= r_action;
         error_ff    <= r_error;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.out_byte     = out_byte_ff;
   assign rsp_if.has_byte     = has_byte_ff;
   assign rsp_if.frame_opcode = opcode_ff;
   assign rsp_if.frame_end    = end_ff;
   assign rsp_if.action       = action_ff;
   assign rsp_if.error_code   = error_ff;

endmodule

### tb/tb_websocket_frame_deframer_core.sv
// Self-checking testbench for websocket_frame_deframer_core: queues masked frames,
// predicts every result with a byte-level parser model and checks the result stream.
// Depends on wfd_pkg, the wfd channel interfaces and websocket_frame_deframer_core.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;
   import wfd_pkg::*;

   localparam logic [3:0]  OP_CONT    = 4'h0;
   localparam logic [3:0]  OP_BINARY  = 4'h2;
   localparam logic [63:0] LEN_LIMIT  = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);
   localparam int          PHASE_BYTES = 310;

   typedef enum logic [2:0] {
      P_HDR, P_LEN, P_EXT16, P_EXT64, P_MASK, P_PAYLOAD, P_DEAD
   } parse_phase_type;

   typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic [3:0] frame_opcode;
      logic       frame_end;
      logic [2:0] action;
      logic [2:0] error_code;
   } deframe_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wfd_req_if req_ch ();
   wfd_rsp_if rsp_ch ();
   wfd_csr_if csr_ch ();

   websocket_frame_deframer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Stream bytes waiting to be sent, results waiting to be seen
   logic [7:0]         tx_bytes[$];
   deframe_result_type expected_results[$];
   int                 queued_bytes = 0;
   int                 mismatches = 0;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;

   // Parser model state
   logic [MAX_BITS-1:0] limit_bytes  = MAX_FRAME_RESET;
   parse_phase_type     parse_phase  = P_HDR;
   logic                fin_seen     = 1'b0;
   logic [3:0]          opcode_cur   = 4'h0;
   logic [3:0]          ext_count    = 4'd0;
   logic [63:0]         length_acc   = 64'd0;
   logic [31:0]         key_word     = 32'd0;
   logic [63:0]         payload_left = 64'd0;
   logic [3:0]          hdr_count    = 4'd0;
   logic [1:0]          u8_pending   = 2'd0;
   logic [20:0]         u8_point     = 21'd0;
   logic                u8_bad       = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic deframe_result_type mk_result(logic [7:0] b, logic has, logic fend,
                                                    logic [2:0] act, logic [2:0] err);
      deframe_result_type r;
      r.out_byte     = b;
      r.has_byte     = has;
      r.frame_opcode = opcode_cur;
      r.frame_end    = fend;
      r.action       = act;
      r.error_code   = err;
      return r;
   endfunction

   function automatic deframe_result_type abort_frame(logic [2:0] err);
      parse_phase = P_DEAD;
      return mk_result(8'h00, 1'b0, 1'b0, ACT_NONE, err);
   endfunction

   // Frame end: pick the action from opcode, FIN and UTF-8 status
   function automatic deframe_result_type end_frame(logic [7:0] b, logic has);
      logic [2:0] act;
      logic [2:0] err;
      act = ACT_NONE;
      err = ERR_NONE;
      if (opcode_cur[3]) begin
         if (opcode_cur == OP_CONN_CLOSE) act = ACT_CLOSE;
         else if (opcode_cur == OP_PING)  act = ACT_PONG;
         else if (opcode_cur == OP_PONG)  act = ACT_IGNORE;
         else                             err = ERR_PROTOCOL;
      end else if (fin_seen) begin
         if (opcode_cur == OP_TEXT && (u8_bad || u8_pending != 2'd0)) err = ERR_UTF8;
         else act = ACT_DELIVER;
      end else begin
         act = ACT_DISCARD;
      end
      hdr_count   = 4'd0;
      parse_phase = (err != ERR_NONE) ? P_DEAD : P_HDR;
      return mk_result(b, has, 1'b1, act, err);
   endfunction

   task automatic deframe_byte(input logic [7:0] b, output bit got,
                               output deframe_result_type r);
      logic [7:0]  o;
      logic [63:0] room;
      int          n;
      got = 1'b0;
      r   = '0;
      if (parse_phase == P_DEAD) return;

      // Payload: unmask, run the UTF-8 check, count down
      if (parse_phase == P_PAYLOAD) begin
         o        = b ^ key_word[7:0];
         key_word = {key_word[7:0], key_word[31:8]};
         if (fin_seen && opcode_cur == OP_TEXT && !u8_bad) begin
            if (u8_pending == 2'd0) begin
               if (o[7]) begin
                  n = 0;
                  while (n < 8 && o[7-n]) n++;
                  if (n < 2 || n > 4) u8_bad = 1'b1;
                  else begin
                     u8_pending = 2'(n - 1);
                     u8_point   = 21'(o & (8'h7F >> n));
                  end
               end
            end else if (o[7:6] != 2'b10) begin
               u8_bad = 1'b1;
            end else begin
               u8_point   = {u8_point[14:0], o[5:0]};
               u8_pending = u8_pending - 2'd1;
               if (u8_pending == 2'd0 && (u8_point > 21'h10FFFF ||
                   (32'(u8_point) - 32'hD800) < 32'h800))
                  u8_bad = 1'b1;
            end
         end
         payload_left = payload_left - 64'd1;
         got = 1'b1;
         if (payload_left == 64'd0) r = end_frame(o, 1'b1);
         else r = mk_result(o, 1'b1, 1'b0, ACT_NONE, ERR_NONE);
         return;
      end

      // Header bytes: count against the frame limit
      if (parse_phase == P_HDR) begin
         hdr_count  = 4'd0;
         u8_pending = 2'd0;
         u8_point   = 21'd0;
         u8_bad     = 1'b0;
      end
      hdr_count = hdr_count + 4'd1;
      if (24'(hdr_count) > limit_bytes) begin
         got = 1'b1;
         r   = abort_frame(ERR_TOO_BIG);
         return;
      end

      case (parse_phase)
         P_HDR: begin
            fin_seen   = b[7];
            opcode_cur = b[3:0];
            if (b[6:4] != 3'b000 || (opcode_cur[3] && !fin_seen)) begin
               got = 1'b1;
               r   = abort_frame(ERR_PROTOCOL);
            end else begin
               parse_phase = P_LEN;
            end
         end
         P_LEN: begin
            if (!b[7]) begin
               got = 1'b1;
               r   = abort_frame(ERR_UNMASKED);
            end else begin
               ext_count = 4'd0;
               key_word  = 32'd0;
               if (b[6:0] >= LEN7_EXT16) begin
                  if (opcode_cur[3]) begin
                     got = 1'b1;
                     r   = abort_frame(ERR_PROTOCOL);
                  end else begin
                     length_acc  = 64'd0;
                     parse_phase = (b[6:0] == LEN7_EXT16) ? P_EXT16 : P_EXT64;
                  end
               end else begin
                  length_acc  = 64'(b[6:0]);
                  parse_phase = P_MASK;
               end
            end
         end
         P_EXT16, P_EXT64: begin
            length_acc = {length_acc[55:0], b};
            ext_count  = ext_count + 4'd1;
            if (ext_count >= ((parse_phase == P_EXT16) ? 4'd2 : 4'd8)) begin
               ext_count   = 4'd0;
               key_word    = 32'd0;
               parse_phase = P_MASK;
            end
         end
         P_MASK: begin
            key_word  = key_word | (32'(b) << (8 * ext_count[1:0]));
            ext_count = ext_count + 4'd1;
            if (ext_count >= 4'd4) begin
               ext_count = 4'd0;
               room = 64'(limit_bytes) - 64'(hdr_count);
               if (length_acc > room || length_acc > LEN_LIMIT) begin
                  got = 1'b1;
                  r   = abort_frame(ERR_TOO_BIG);
               end else begin
                  payload_left = length_acc;
                  parse_phase  = P_PAYLOAD;
                  if (payload_left == 64'd0) begin
                     got = 1'b1;
                     r   = end_frame(8'h00, 1'b0);
                  end
               end
            end
         end
         default: parse_phase = P_DEAD;
      endcase
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_proc
      bit                 got;
      deframe_result_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.in_byte, got, r);
            if (got) expected_results.push_back(r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.in_byte <= tx_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_proc
      deframe_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing pending: out_byte %0h frame_end %0b error_code %0d",
                      rsp_ch.out_byte, rsp_ch.frame_end, rsp_ch.error_code);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("out_byte", 8'(want.out_byte), 8'(rsp_ch.out_byte));
               check_field("has_byte", 8'(want.has_byte), 8'(rsp_ch.has_byte));
               check_field("frame_opcode", 8'(want.frame_opcode), 8'(rsp_ch.frame_opcode));
               check_field("frame_end", 8'(want.frame_end), 8'(rsp_ch.frame_end));
               check_field("action", 8'(want.action), 8'(rsp_ch.action));
               check_field("error_code", 8'(want.error_code), 8'(rsp_ch.error_code));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      queued_bytes++;
   endtask

   task automatic queue_header(input logic fin, input logic [3:0] op, input len_form_type form,
                               input logic [63:0] n, input logic [31:0] key);
      int i;
      push_byte({fin, 3'b000, op});
      case (form)
         LEN_SHORT: push_byte({1'b1, n[6:0]});
         LEN_16: begin
            push_byte({1'b1, LEN7_EXT16});
            push_byte(n[15:8]);
            push_byte(n[7:0]);
         end
         default: begin
            push_byte({1'b1, LEN7_EXT64});
            for (i = 7; i >= 0; i--) push_byte(n[8*i +: 8]);
         end
      endcase
      for (i = 0; i < 4; i++) push_byte(key[8*i +: 8]);
   endtask

   task automatic queue_frame(input logic fin, input logic [3:0] op, input len_form_type form,
                              input logic [31:0] key, input logic [7:0] body[$]);
      int i;
      queue_header(fin, op, form, 64'(body.size()), key);
      for (i = 0; i < body.size(); i++) push_byte(body[i] ^ key[8*(i%4) +: 8]);
   endtask

   // Well-formed frame of random type, size and content that fits the limit
   task automatic queue_random_frame();
      logic [7:0]   body[$];
      logic [3:0]   op;
      logic         fin;
      logic [20:0]  cp;
      len_form_type form;
      int           pick, room, len, k, left, i;
      pick = $urandom_range(99);
      if (pick < 20) begin
         op  = OP_CONN_CLOSE + 4'($urandom_range(2));
         fin = 1'b1;
      end else if (pick < 45) begin
         op  = OP_TEXT;
         fin = ($urandom_range(3) != 0);
      end else begin
         op  = 4'($urandom_range(7));
         if (op == OP_TEXT) op = OP_BINARY;
         fin = 1'($urandom_range(1));
      end
      pick = $urandom_range(99);
      if (op[3] || pick < 70) form = LEN_SHORT;
      else if (pick < 88) form = LEN_16;
      else form = LEN_64;
      room = int'(limit_bytes) - ((form == LEN_SHORT) ? 6 : (form == LEN_16) ? 8 : 14);
      pick = $urandom_range(99);
      if (pick < 65) len = $urandom_range(10);
      else if (pick < 95) len = $urandom_range(40, 11);
      else len = $urandom_range(300, 61);
      if (form == LEN_SHORT && len > 125) len = 125;
      if (len > room) len = room;

      if (op == OP_TEXT && fin) begin
         // valid UTF-8, overlong forms included
         while (body.size() < len) begin
            left = len - body.size();
            k = $urandom_range((left < 4) ? left : 4, 1);
            case (k)
               1:       cp = 21'($urandom_range(32'h7F));
               2:       cp = 21'($urandom_range(32'h7FF));
               3:       cp = 21'($urandom_range(32'hFFFF));
               default: cp = 21'($urandom_range(32'h10FFFF));
            endcase
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp + 21'h800;
            case (k)
               1: body.push_back({1'b0, cp[6:0]});
               2: begin
                  body.push_back({3'b110, cp[10:6]});
                  body.push_back({2'b10, cp[5:0]});
               end
               3: begin
                  body.push_back({4'b1110, cp[15:12]});
                  body.push_back({2'b10, cp[11:6]});
                  body.push_back({2'b10, cp[5:0]});
               end
               default: begin
                  body.push_back({5'b11110, cp[20:18]});
                  body.push_back({2'b10, cp[17:12]});
                  body.push_back({2'b10, cp[11:6]});
                  body.push_back({2'b10, cp[5:0]});
               end
            endcase
         end
      end else begin
         for (i = 0; i < len; i++) body.push_back(8'($urandom));
      end
      queue_frame(fin, op, form, $urandom, body);
   endtask

   // One fatal violation, then bytes that must be ignored
   task automatic queue_fatal_case();
      logic [7:0]  body[$];
      logic [7:0]  b;
      logic [63:0] n;
      int          pick, i;
      pick = $urandom_range(7);
      case (pick)
         0: begin
            // reserved bits set
            b = 8'($urandom);
            b[6:4] = 3'($urandom_range(7, 1));
            push_byte(b);
         end
         1: push_byte({1'b0, 3'b000, 1'b1, 3'($urandom)});   // fragmented control
         2: begin
            push_byte({1'b1, 3'b000, OP_BINARY});
            push_byte({1'b0, 7'($urandom)});               // mask bit clear
         end
         3: begin
            // control frame with an extended length
            push_byte({1'b1, 3'b000, 4'($urandom_range(15, 8))});
            push_byte({1'b1, ($urandom_range(1) != 0) ? LEN7_EXT16 : LEN7_EXT64});
         end
         4: begin
            // limit below the header size: fails while the header is counted
            write_frame_limit(24'($urandom_range(13)));
            queue_header(1'b1, OP_BINARY, LEN_64, {$urandom, $urandom}, $urandom);
         end
         5: begin
            // payload just past the room, or past the length counter
            n = 64'(limit_bytes) - 64'd7;
            if (n <= 64'hFFFF && $urandom_range(1) != 0)
               queue_header(1'b1, OP_BINARY, LEN_16, n, $urandom);
            else
               queue_header(1'b0, OP_CONT, LEN_64, {$urandom, $urandom} | 64'h0100_0000,
                            $urandom);
         end
         6: begin
            // final text frame with broken UTF-8
            for (i = 0; i < $urandom_range(3); i++) body.push_back(8'($urandom_range(8'h7E, 8'h20)));
            case ($urandom_range(5))
               0: begin body.push_back(8'hED); body.push_back(8'hA0); body.push_back(8'h80); end
               1: begin
                  body.push_back(8'hF4); body.push_back(8'h90);
                  body.push_back(8'h80); body.push_back(8'h80);
               end
               2: begin body.push_back(8'hE2); body.push_back(8'h82); end
               3: body.push_back(8'h80);
               4: body.push_back(8'hF8);
               default: begin body.push_back(8'hC3); body.push_back(8'h41); end
            endcase
            queue_frame(1'b1, OP_TEXT, LEN_SHORT, $urandom, body);
         end
         default: begin
            // invalid control opcode
            for (i = 0; i < $urandom_range(5); i++) body.push_back(8'($urandom));
            queue_frame(1'b1, 4'($urandom_range(15, 11)), LEN_SHORT, $urandom, body);
         end
      endcase
      repeat (16) push_byte(8'($urandom));
   endtask

   task automatic write_frame_limit(input logic [MAX_BITS-1:0] value);
      @(posedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.max_frame_bytes <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      limit_bytes = value;
   endtask

   // Wait until every byte is in and every result is out, then let the pipe empty
   task automatic wait_drained();
      do @(posedge clock);
      while (tx_bytes.size() != 0 || req_ch.valid || expected_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random_phase(input logic [MAX_BITS-1:0] limit, input int idle_pct,
                                   input int stall);
      int start;
      write_frame_limit(limit);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      start = queued_bytes;
      while (queued_bytes - start < PHASE_BYTES) queue_random_frame();
      wait_drained();
   endtask

   initial begin : main_proc
      logic [7:0] body[$];
      req_ch.valid           = 1'b0;
      req_ch.in_byte         = 8'h00;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.max_frame_bytes = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset limit, no idling
      body.delete();
      queue_frame(1'b1, OP_PING, LEN_SHORT, 32'h0000_0000, body);   // empty payload
      body.delete();
      body.push_back(8'hF4); body.push_back(8'h8F); body.push_back(8'hBF);
      body.push_back(8'hBF); body.push_back(8'hC0); body.push_back(8'h80);
      body.push_back(8'h7F);                                        // U+10FFFF, overlong NUL
      queue_frame(1'b1, OP_TEXT, LEN_SHORT, 32'hFFFF_FFFF, body);
      body.delete();
      body.push_back(8'h00); body.push_back(8'hFF);
      queue_frame(1'b0, OP_BINARY, LEN_16, 32'h3CC3_5AA5, body);    // fragment
      body.delete();
      body.push_back(8'h55);
      queue_frame(1'b1, OP_CONT, LEN_64, 32'h0804_0201, body);
      wait_drained();

      // Random traffic over several limits and idle patterns
      run_random_phase(24'd14, 50, 0);
      run_random_phase(24'hFFFFFF, 0, 50);
      run_random_phase(24'($urandom_range(64, 15)), 17, 17);
      run_random_phase(24'($urandom_range(70000, 65)), 0, 0);
      run_random_phase(MAX_FRAME_RESET, 17, 17);

      // One fatal error ends the useful life of the block
      send_idle_pct = 17;
      stall_pct     = 17;
      queue_fatal_case();
      wait_drained();

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### filelist.f
hdl/wfd_pkg.sv
hdl/wfd_channels.sv
hdl/wfd_utf8.sv
hdl/websocket_frame_deframer_core.sv
tb/tb_websocket_frame_deframer_core.sv
